// ===== rtl/u2f_pkg.sv =====
package u2f_pkg;

	typedef enum logic [2:0] {
		VERDICT_VERSION    = 3'd0,
		VERDICT_REG_READY  = 3'd1,
		VERDICT_AUTH_READY = 3'd2,
		VERDICT_INS_UNSUP  = 3'd3,
		VERDICT_WRONG_LEN  = 3'd4,
		VERDICT_CLA_UNSUP  = 3'd5,
		VERDICT_BAD_P1P2   = 3'd6
	} verdict_t;

	localparam logic [15:0] SW_NO_ERROR   = 16'h9000;
	localparam logic [15:0] SW_FORWARD    = 16'h0000;
	localparam logic [15:0] SW_WRONG_LEN  = 16'h6700;
	localparam logic [15:0] SW_WRONG_DATA = 16'h6A86;
	localparam logic [15:0] SW_INS_UNSUP  = 16'h6D00;
	localparam logic [15:0] SW_CLA_UNSUP  = 16'h6E00;

	localparam logic [7:0] INS_REGISTER     = 8'h01;
	localparam logic [7:0] INS_AUTHENTICATE = 8'h02;
	localparam logic [7:0] INS_VERSION      = 8'h03;

	localparam logic [7:0] P1_ENFORCE      = 8'h03;
	localparam logic [7:0] P1_CHECK_ONLY   = 8'h07;
	localparam logic [7:0] P1_DONT_ENFORCE = 8'h08;

	localparam int REG_DATA_LEN  = 64;
	localparam int AUTH_BASE_LEN = 65;

	// byte positions inside the APDU
	localparam int IDX_CLA        = 0;
	localparam int IDX_INS        = 1;
	localparam int IDX_P1         = 2;
	localparam int IDX_LC         = 4;
	localparam int IDX_LC_HI      = 5;
	localparam int IDX_LC_LO      = 6;
	localparam int IDX_HANDLE_SHT = IDX_LC + 1 + REG_DATA_LEN;
	localparam int IDX_HANDLE_EXT = IDX_LC + 3 + REG_DATA_LEN;

	localparam logic [1:0] CFG_ADDR_FEATURE = 2'd0;

	typedef struct packed {
		logic [7:0]  cla;
		logic [7:0]  ins;
		logic [7:0]  p1;
		logic [15:0] length;
		logic        ext;
		logic [7:0]  handle_len;
		logic        ovf;
	} frame_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [15:0] status_word;
		logic [7:0]  instruction;
		logic [7:0]  control_byte;
		logic [15:0] body_length;
		logic [7:0]  handle_length;
	} result_t;

endpackage

// ===== rtl/u2f_in_if.sv =====
interface u2f_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] apdu_byte;
	logic       last_byte;

	modport source (output valid, output apdu_byte, output last_byte, input ready);
	modport sink (input valid, input apdu_byte, input last_byte, output ready);
endinterface

// ===== rtl/u2f_out_if.sv =====
interface u2f_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [15:0] status_word;
	logic [7:0]  instruction;
	logic [7:0]  control_byte;
	logic [15:0] body_length;
	logic [7:0]  handle_length;

	modport source (output valid, output verdict, output status_word, output instruction,
		output control_byte, output body_length, output handle_length, input ready);
	modport sink (input valid, input verdict, input status_word, input instruction,
		input control_byte, input body_length, input handle_length, output ready);
endinterface

// ===== rtl/u2f_verdict.sv =====
module u2f_verdict import u2f_pkg::*; #(
	parameter int COUNT_BITS = 17
) (
	input  logic                  feature_en,
	input  frame_t                fr,
	input  logic [COUNT_BITS-1:0] n,
	output result_t               res
);

	logic [COUNT_BITS-1:0] r;
	logic [COUNT_BITS-1:0] need;
	logic [COUNT_BITS-1:0] trail;
	logic [COUNT_BITS-1:0] max_le;
	logic                  has_hdr;
	logic                  no_body;
	logic                  frame_good;
	logic [15:0]           dlen;
	logic [15:0]           auth_len;
	logic                  p1_ok;

	assign has_hdr = n >= COUNT_BITS'(4);
	assign r       = n - COUNT_BITS'(4);
	assign no_body = has_hdr && (r <= COUNT_BITS'(1));
	assign need    = (fr.ext ? COUNT_BITS'(3) : COUNT_BITS'(1)) + COUNT_BITS'(fr.length);
	assign trail   = r - need;
	assign max_le  = fr.ext ? COUNT_BITS'(2) : COUNT_BITS'(1);

	always_comb begin
		frame_good = 1'b0;
		dlen       = 16'd0;
		if (!has_hdr) begin
			frame_good = 1'b0;
		end else if (no_body) begin
			frame_good = 1'b1;
		end else if (r < need) begin
			frame_good = 1'b0;
		end else if (trail > max_le) begin
			frame_good = 1'b0;
		end else begin
			frame_good = 1'b1;
			dlen       = fr.length;
		end
		if (fr.ovf) begin
			frame_good = 1'b0;
		end
	end

	assign auth_len = 16'(AUTH_BASE_LEN) + {8'd0, fr.handle_len};
	assign p1_ok    = (fr.p1 == P1_ENFORCE) || (fr.p1 == P1_CHECK_ONLY) ||
		(fr.p1 == P1_DONT_ENFORCE);

	always_comb begin
		res.instruction   = fr.ins;
		res.control_byte  = fr.p1;
		res.body_length   = no_body ? 16'd0 : fr.length;
		res.handle_length = fr.handle_len;
		if (!feature_en) begin
			res.verdict     = VERDICT_INS_UNSUP;
			res.status_word = SW_INS_UNSUP;
		end else if (!frame_good) begin
			res.verdict     = VERDICT_WRONG_LEN;
			res.status_word = SW_WRONG_LEN;
		end else if (fr.cla != 8'd0) begin
			res.verdict     = VERDICT_CLA_UNSUP;
			res.status_word = SW_CLA_UNSUP;
		end else if (fr.ins == INS_VERSION) begin
			res.verdict     = VERDICT_VERSION;
			res.status_word = SW_NO_ERROR;
		end else if (fr.ins == INS_REGISTER) begin
			if (dlen != 16'(REG_DATA_LEN)) begin
				res.verdict     = VERDICT_WRONG_LEN;
				res.status_word = SW_WRONG_LEN;
			end else begin
				res.verdict     = VERDICT_REG_READY;
				res.status_word = SW_FORWARD;
			end
		end else if (fr.ins == INS_AUTHENTICATE) begin
			// auth_len is at least the minimum, so one compare covers both checks
			if (dlen != auth_len) begin
				res.verdict     = VERDICT_WRONG_LEN;
				res.status_word = SW_WRONG_LEN;
			end else if (!p1_ok) begin
				res.verdict     = VERDICT_BAD_P1P2;
				res.status_word = SW_WRONG_DATA;
			end else begin
				res.verdict     = VERDICT_AUTH_READY;
				res.status_word = SW_FORWARD;
			end
		end else begin
			res.verdict     = VERDICT_INS_UNSUP;
			res.status_word = SW_INS_UNSUP;
		end
	end

endmodule

// ===== rtl/u2f_apdu_frame_checker.sv =====
// channel   dir  payload                                              handshake
// in_ch     in   apdu_byte[7:0] last_byte                             valid/ready
// out_ch    out  verdict[2:0] status_word[15:0] instruction[7:0]      valid/ready
//                control_byte[7:0] body_length[15:0] handle_length[7:0]
// apb       in   feature_enabled at byte address 0                    psel/penable
//
// One byte per cycle unless a last byte waits on a stalled output. A byte sits first
// in the input register, then the frame state and, on the last byte, the verdict are
// computed in one pass into the output register.
// A stalled output only holds a pending last byte; other bytes keep flowing.
// Reset clears all frame state and feature_enabled; no clearing pass.
module u2f_apdu_frame_checker import u2f_pkg::*; #(
	parameter int COUNT_BITS = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	u2f_in_if.sink      in_ch,
	u2f_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  go_s1;

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_n;
	frame_t                frame_q;
	frame_t                frame_n;
	logic                  feature_q;

	logic                  out_valid_q;
	result_t               res_q;
	result_t               res;

	// config
	assign pready = 1'b1;
	assign prdata = {31'd0, feature_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == CFG_ADDR_FEATURE) begin
			feature_q <= pwdata[0];
		end
	end

	// input register
	assign go_s1       = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.apdu_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// frame state update
	always_comb begin
		frame_n = frame_q;
		if (!frame_q.ovf) begin
			if (count_q == COUNT_BITS'(IDX_CLA)) begin
				frame_n.cla = byte_s1;
			end else if (count_q == COUNT_BITS'(IDX_INS)) begin
				frame_n.ins = byte_s1;
			end else if (count_q == COUNT_BITS'(IDX_P1)) begin
				frame_n.p1 = byte_s1;
			end else if (count_q == COUNT_BITS'(IDX_LC)) begin
				frame_n.length = {8'd0, byte_s1};
				frame_n.ext    = (byte_s1 == 8'd0);
			end else if (count_q == COUNT_BITS'(IDX_LC_HI) && frame_q.ext) begin
				frame_n.length = {byte_s1, frame_q.length[7:0]};
			end else if (count_q == COUNT_BITS'(IDX_LC_LO) && frame_q.ext) begin
				frame_n.length = {frame_q.length[15:8], byte_s1};
			end else if ((count_q == COUNT_BITS'(IDX_HANDLE_SHT) && !frame_q.ext) ||
				(count_q == COUNT_BITS'(IDX_HANDLE_EXT) && frame_q.ext)) begin
				frame_n.handle_len = byte_s1;
			end
		end
		if (count_q == {COUNT_BITS{1'b1}}) begin
			count_n     = count_q;
			frame_n.ovf = 1'b1;
		end else begin
			count_n = count_q + COUNT_BITS'(1);
		end
	end

	u2f_verdict #(
		.COUNT_BITS(COUNT_BITS)
	) u_verdict (
		.feature_en(feature_q),
		.fr        (frame_n),
		.n         (count_n),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			frame_q <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				count_q <= '0;
				frame_q <= '0;
			end else begin
				count_q <= count_n;
				frame_q <= frame_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.verdict       = res_q.verdict;
	assign out_ch.status_word   = res_q.status_word;
	assign out_ch.instruction   = res_q.instruction;
	assign out_ch.control_byte  = res_q.control_byte;
	assign out_ch.body_length   = res_q.body_length;
	assign out_ch.handle_length = res_q.handle_length;

endmodule

// ===== rtl/u2f_checker.sv =====
module u2f_checker import u2f_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  out_verdict,
	input logic [15:0] out_status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_verdict) && $stable(out_status))
		else $error("result dropped or changed while stalled");

	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("result without a last byte two cycles earlier");

	a_forward_sw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_verdict == VERDICT_REG_READY || out_verdict == VERDICT_AUTH_READY)
		|-> out_status == SW_FORWARD)
		else $error("forwarded command with nonzero status");

	a_error_sw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_verdict == VERDICT_WRONG_LEN |-> out_status == SW_WRONG_LEN)
		else $error("wrong length verdict with other status");

endmodule

bind u2f_apdu_frame_checker u2f_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_last    (in_ch.last_byte),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_verdict(out_ch.verdict),
	.out_status (out_ch.status_word)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

import u2f_pkg::*;

class verdict_predictor #(int CNT_W = 17);
	bit [CNT_W-1:0] byte_count;
	bit             count_ovf;
	logic [7:0]     cla;
	logic [7:0]     ins;
	logic [7:0]     p1;
	logic [15:0]    lc_val;
	bit             ext;
	logic [7:0]     kh;
	bit             feature_en;
	result_t        pending_verdicts[$];
	int             errors;
	int             checked;
	int             seen[8];

	function new();
		clear_frame();
	endfunction

	function void clear_frame();
		byte_count = '0;
		count_ovf  = 0;
		cla        = '0;
		ins        = '0;
		p1         = '0;
		lc_val     = '0;
		ext        = 0;
		kh         = '0;
	endfunction

	function bit frame_good(int unsigned n, output int unsigned dlen);
		int unsigned r;
		int unsigned off;
		int unsigned maxle;
		dlen = 0;
		if (n < 4)
			return 0;
		r = n - 4;
		if (r <= 1)
			return 1;
		if (!ext) begin
			off   = 1;
			maxle = 1;
		end else begin
			if (r < 3)
				return 0;
			off   = 3;
			maxle = 2;
		end
		if (r < off + lc_val)
			return 0;
		if (r - off - lc_val > maxle)
			return 0;
		dlen = lc_val;
		return 1;
	endfunction

	function void note_byte(logic [7:0] b, logic last);
		int unsigned idx;
		int unsigned n;
		int unsigned dlen;
		bit          good;
		result_t     r;
		idx = byte_count;
		if (!count_ovf) begin
			if (idx == IDX_CLA)
				cla = b;
			else if (idx == IDX_INS)
				ins = b;
			else if (idx == IDX_P1)
				p1 = b;
			else if (idx == IDX_LC) begin
				if (b != 0) begin
					lc_val = {8'h00, b};
					ext    = 0;
				end else begin
					lc_val = '0;
					ext    = 1;
				end
			end else if (idx == IDX_LC_HI && ext)
				lc_val[15:8] = b;
			else if (idx == IDX_LC_LO && ext)
				lc_val[7:0] = b;
			else if ((idx == IDX_HANDLE_SHT && !ext) || (idx == IDX_HANDLE_EXT && ext))
				kh = b;
		end
		if (&byte_count)
			count_ovf = 1;
		else
			byte_count++;
		if (!last)
			return;

		n    = byte_count;
		dlen = 0;
		good = !count_ovf && frame_good(n, dlen);
		r.instruction   = ins;
		r.control_byte  = p1;
		r.handle_length = kh;
		r.body_length   = (n >= 4 && n - 4 <= 1) ? 16'h0000 : lc_val;
		if (!feature_en) begin
			r.verdict = VERDICT_INS_UNSUP; r.status_word = SW_INS_UNSUP;
		end else if (!good) begin
			r.verdict = VERDICT_WRONG_LEN; r.status_word = SW_WRONG_LEN;
		end else if (cla != 0) begin
			r.verdict = VERDICT_CLA_UNSUP; r.status_word = SW_CLA_UNSUP;
		end else if (ins == INS_VERSION) begin
			r.verdict = VERDICT_VERSION; r.status_word = SW_NO_ERROR;
		end else if (ins == INS_REGISTER) begin
			if (dlen != REG_DATA_LEN) begin
				r.verdict = VERDICT_WRONG_LEN; r.status_word = SW_WRONG_LEN;
			end else begin
				r.verdict = VERDICT_REG_READY; r.status_word = SW_FORWARD;
			end
		end else if (ins == INS_AUTHENTICATE) begin
			if (dlen < AUTH_BASE_LEN || dlen != AUTH_BASE_LEN + kh) begin
				r.verdict = VERDICT_WRONG_LEN; r.status_word = SW_WRONG_LEN;
			end else if (p1 != P1_ENFORCE && p1 != P1_CHECK_ONLY && p1 != P1_DONT_ENFORCE) begin
				r.verdict = VERDICT_BAD_P1P2; r.status_word = SW_WRONG_DATA;
			end else begin
				r.verdict = VERDICT_AUTH_READY; r.status_word = SW_FORWARD;
			end
		end else begin
			r.verdict = VERDICT_INS_UNSUP; r.status_word = SW_INS_UNSUP;
		end
		pending_verdicts.insert(pending_verdicts.size(), r);
		clear_frame();
	endfunction

	task flag_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch %s: got 'h%0h, expected 'h%0h (verdict %0d)", what, got, want,
			checked);
	endtask

	task check_verdict(result_t got);
		result_t want;
		if (pending_verdicts.size() == 0) begin
			flag_mismatch("verdict with none pending", got.verdict, 0);
			return;
		end
		want = pending_verdicts.pop_front();
		if (got.verdict !== want.verdict)
			flag_mismatch("verdict", got.verdict, want.verdict);
		if (got.status_word !== want.status_word)
			flag_mismatch("status_word", got.status_word, want.status_word);
		if (got.instruction !== want.instruction)
			flag_mismatch("instruction", got.instruction, want.instruction);
		if (got.control_byte !== want.control_byte)
			flag_mismatch("control_byte", got.control_byte, want.control_byte);
		if (got.body_length !== want.body_length)
			flag_mismatch("body_length", got.body_length, want.body_length);
		if (got.handle_length !== want.handle_length)
			flag_mismatch("handle_length", got.handle_length, want.handle_length);
		seen[want.verdict]++;
		checked++;
	endtask
endclass

module testbench;
	localparam int COUNT_BITS  = 17;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 4;

	typedef enum {FORM_NONE, FORM_SHORT, FORM_EXT} lc_form_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	u2f_in_if  in_ch ();
	u2f_out_if out_ch ();

	u2f_apdu_frame_checker #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	verdict_predictor #(COUNT_BITS) sb = new;

	logic [7:0] frame_q[$];
	bit         no_idle;
	bit         hold_req;
	int         item_total;
	int         cmd_total;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function void add_byte(logic [7:0] b);
		frame_q.insert(frame_q.size(), b);
	endfunction

	function void make_frame(logic [7:0] cla, logic [7:0] ins, logic [7:0] p1, logic [7:0] p2,
			lc_form_t form, int lc, int dlen_n, logic [7:0] kh, int le_n);
		frame_q.delete();
		add_byte(cla);
		add_byte(ins);
		add_byte(p1);
		add_byte(p2);
		if (form == FORM_SHORT)
			add_byte(lc[7:0]);
		else if (form == FORM_EXT) begin
			add_byte(8'h00);
			add_byte(lc[15:8]);
			add_byte(lc[7:0]);
		end
		for (int i = 0; i < dlen_n; i++)
			add_byte(i == REG_DATA_LEN ? kh : 8'($urandom));
		repeat (le_n) add_byte(8'($urandom));
	endfunction

	function void gen_random_frame();
		int         kind;
		int         lc;
		int         dlen_n;
		int         le_n;
		int         maxle;
		bit         ext;
		logic [7:0] cla;
		logic [7:0] ins;
		logic [7:0] p1;
		logic [7:0] kh;
		kind = $urandom_range(99);
		ext  = ($urandom_range(2) == 0);
		kh   = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
		cla  = 8'h00;
		p1   = 8'($urandom);
		if (kind >= 85) begin
			frame_q.delete();
			repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
			if ($urandom_range(1))
				frame_q[0] = 8'h00;
			return;
		end
		if (kind < 14) begin
			if ($urandom_range(3) == 0) begin
				lc = $urandom_range(1, 8);
				make_frame(cla, INS_VERSION, p1, 8'($urandom), FORM_SHORT, lc, lc, kh,
					$urandom_range(1));
			end else
				make_frame(cla, INS_VERSION, p1, 8'($urandom), FORM_NONE, 0, 0, kh,
					$urandom_range(1));
			return;
		end
		if (kind < 34 || (kind >= 60 && $urandom_range(1))) begin
			ins = INS_REGISTER;
			lc  = REG_DATA_LEN;
		end else begin
			ins = INS_AUTHENTICATE;
			lc  = AUTH_BASE_LEN + kh;
			if ($urandom_range(99) < 85) begin
				case ($urandom_range(2))
					0: p1 = P1_ENFORCE;
					1: p1 = P1_CHECK_ONLY;
					default: p1 = P1_DONT_ENFORCE;
				endcase
			end
		end
		if (lc > 255)
			ext = 1;
		maxle  = ext ? 2 : 1;
		le_n   = $urandom_range(maxle);
		dlen_n = lc;
		if (kind >= 60) begin
			case ($urandom_range(4))
				0: begin
					lc     = $urandom_range(1) ? lc + 1 : lc - 1;
					dlen_n = lc;
				end
				1: dlen_n = lc - $urandom_range(1, 3);
				2: le_n = maxle + $urandom_range(1, 2);
				3: cla = 8'($urandom_range(1, 255));
				default: ins = 8'($urandom);
			endcase
		end
		if (lc > 255)
			ext = 1;
		make_frame(cla, ins, p1, 8'($urandom), ext ? FORM_EXT : FORM_SHORT, lc, dlen_n, kh,
			le_n);
	endfunction

	task send_item(logic [7:0] b, logic last);
		if (!no_idle) begin
			while ($urandom_range(99) < 13) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid     <= 1'b1;
		in_ch.apdu_byte <= b;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_byte(b, last);
		item_total++;
	endtask

	task send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_item(frame_q[i], i == frame_q.size() - 1);
		cmd_total++;
	endtask

	task send_cmd(logic [7:0] cla, logic [7:0] ins, logic [7:0] p1, lc_form_t form, int lc,
			int dlen_n, logic [7:0] kh, int le_n);
		make_frame(cla, ins, p1, 8'($urandom), form, lc, dlen_n, kh, le_n);
		send_frame();
	endtask

	task send_noise(int n);
		frame_q.delete();
		repeat (n) add_byte(8'($urandom));
		send_frame();
	endtask

	task settle();
		in_ch.valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task apb_write(logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_FEATURE;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.feature_en = v[0];
		@(posedge clk);
	endtask

	task apb_check();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= CFG_ADDR_FEATURE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {31'b0, sb.feature_en})
			sb.flag_mismatch("feature_enabled readback", prdata, sb.feature_en);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task run_random(int n_items, int n_verdicts);
		int start_items;
		int start_checked;
		int k;
		start_items   = item_total;
		start_checked = sb.checked + sb.pending_verdicts.size();
		k = 0;
		while (item_total - start_items < n_items ||
				sb.checked + sb.pending_verdicts.size() - start_checked < n_verdicts) begin
			no_idle = (k >= 1 && k < 3);
			gen_random_frame();
			send_frame();
			k++;
		end
		no_idle = 0;
	endtask

	// receive side
	initial begin : rx_proc
		result_t got;
		int      hold_left;
		bit      hold_done;
		hold_left = 0;
		hold_done = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.verdict       = verdict_t'(out_ch.verdict);
				got.status_word   = out_ch.status_word;
				got.instruction   = out_ch.instruction;
				got.control_byte  = out_ch.control_byte;
				got.body_length   = out_ch.body_length;
				got.handle_length = out_ch.handle_length;
				sb.check_verdict(got);
			end
			if (hold_req && !hold_done) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (no_idle)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(99) >= 13);
		end
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall = 0;
			else
				stall++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.apdu_byte <= 8'h00;
		in_ch.last_byte <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		no_idle  = 0;
		hold_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// feature off after reset
		apb_check();
		send_cmd(8'h00, INS_VERSION, 8'h00, FORM_NONE, 0, 0, 8'h00, 0);
		send_noise(1);
		settle();

		apb_write(32'h1);
		apb_check();
		send_noise(1);
		send_noise(2);
		send_noise(3);
		send_cmd(8'h00, INS_VERSION, 8'h00, FORM_NONE, 0, 0, 8'h00, 0);
		send_cmd(8'h00, INS_VERSION, 8'hFF, FORM_NONE, 0, 0, 8'h00, 1);
		send_cmd(8'hFF, INS_VERSION, 8'h00, FORM_NONE, 0, 0, 8'h00, 0);
		send_cmd(8'h00, INS_REGISTER, 8'h03, FORM_SHORT, 64, 64, 8'h00, 0);
		send_cmd(8'h00, INS_REGISTER, 8'h00, FORM_SHORT, 2, 2, 8'h00, 0);
		send_cmd(8'h00, INS_AUTHENTICATE, P1_ENFORCE, FORM_SHORT, 65, 65, 8'h00, 0);
		send_cmd(8'h00, INS_AUTHENTICATE, P1_CHECK_ONLY, FORM_SHORT, 66, 66, 8'h01, 1);
		send_cmd(8'h00, INS_AUTHENTICATE, P1_DONT_ENFORCE, FORM_EXT, 67, 67, 8'h02, 2);
		send_cmd(8'h00, INS_AUTHENTICATE, 8'h00, FORM_SHORT, 66, 66, 8'h01, 0);
		send_cmd(8'h00, INS_AUTHENTICATE, P1_ENFORCE, FORM_SHORT, 3, 3, 8'h00, 0);
		send_cmd(8'h00, 8'hFF, 8'h00, FORM_NONE, 0, 0, 8'h00, 0);
		send_cmd(8'h00, 8'h00, 8'h00, FORM_SHORT, 2, 2, 8'h00, 0);
		send_cmd(8'h00, INS_VERSION, 8'h00, FORM_SHORT, 1, 1, 8'h00, 2);
		send_cmd(8'h00, INS_VERSION, 8'h00, FORM_EXT, 1, 1, 8'h00, 3);
		send_cmd(8'h00, INS_VERSION, 8'h00, FORM_NONE, 0, 0, 8'h00, 2);
		send_cmd(8'h00, INS_VERSION, 8'h00, FORM_EXT, 0, 0, 8'h00, 0);
		send_cmd(8'h00, INS_REGISTER, 8'h00, FORM_EXT, 16'hFFFF, 0, 8'h00, 0);
		settle();

		run_random(150, 4);
		settle();

		apb_write(32'h0);
		apb_check();
		run_random(40, 3);
		settle();

		apb_write(32'h1);
		apb_check();
		hold_req = 1;
		no_idle  = 1;
		repeat (12) send_cmd(8'h00, INS_VERSION, 8'($urandom), FORM_NONE, 0, 0, 8'h00,
			$urandom_range(1));
		no_idle = 0;
		run_random(150, 4);
		settle();

		$display("covered %0d bytes in %0d commands: feature off and on, output hold-off;",
			item_total, cmd_total);
		$display("  verdicts ver %0d reg %0d auth %0d ins %0d len %0d cla %0d p1 %0d",
			sb.seen[VERDICT_VERSION], sb.seen[VERDICT_REG_READY], sb.seen[VERDICT_AUTH_READY],
			sb.seen[VERDICT_INS_UNSUP], sb.seen[VERDICT_WRONG_LEN], sb.seen[VERDICT_CLA_UNSUP],
			sb.seen[VERDICT_BAD_P1P2]);
		if (sb.errors == 0 && sb.pending_verdicts.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
